// ----- hw/rtl/prq_pkg.sv -----
// Shared types, constants and the ordering function for the priority ready queue.
`default_nettype none

package prq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int PID_W           = 16;
  localparam int PRIO_W          = 4;
  localparam int TIME_W          = 32;
  localparam int IN_TDATA_W      = 88;
  localparam int OUT_TDATA_W     = 16;

  localparam logic [PRIO_W-1:0] MAX_PRIO = PRIO_W'(9);
  localparam logic [PID_W-1:0]  PID_NONE = '0;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  typedef struct packed {
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] ready;
  } entry_t;

  // Per-cell commands from the top level.
  typedef struct packed {
    logic cap;         // latch the compare flags for the incoming request
    logic load_new;    // take the new entry
    logic take_left;   // shift toward the tail
    logic take_right;  // shift toward the head
  } cell_ctl_t;

  typedef struct packed {
    logic ahead;   // new entry sorts ahead of this cell (or the cell is empty)
    logic dup;     // this cell holds the same id
  } cell_flag_t;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_t;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_REJECTED = 2'd1,
    STAT_SELECTED = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  // True if entry a must stand before entry b.
  function automatic logic goes_before(entry_t a, entry_t b);
    logic res;
    if (a.prio != b.prio) begin
      res = a.prio < b.prio;
    end else if (a.ready != b.ready) begin
      res = a.ready < b.ready;
    end else begin
      res = a.pid < b.pid;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/prq_cell.sv -----
// One slot of the sorted queue: holds an entry, compares it and shifts with its neighbors.
`default_nettype none

module prq_cell (
  input  wire logic               clk,
  input  wire prq_pkg::cell_ctl_t ctl,
  input  wire logic               valid,
  input  wire prq_pkg::entry_t    cmp_item,
  input  wire prq_pkg::entry_t    new_item,
  input  wire prq_pkg::entry_t    left_entry,
  input  wire prq_pkg::entry_t    right_entry,
  output prq_pkg::entry_t         entry,
  output prq_pkg::cell_flag_t     flag
);
  import prq_pkg::*;

  entry_t     entry_r;
  cell_flag_t flag_r;

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      flag_r.ahead <= !valid || goes_before(cmp_item, entry_r);
      flag_r.dup   <= valid && (entry_r.pid == cmp_item.pid);
    end
  end

  always_ff @(posedge clk) begin
    priority if (ctl.load_new) begin
      entry_r <= new_item;
    end else if (ctl.take_left) begin
      entry_r <= left_entry;
    end else if (ctl.take_right) begin
      entry_r <= right_entry;
    end else begin
      entry_r <= entry_r;
    end
  end

  assign entry = entry_r;
  assign flag  = flag_r;

endmodule

`default_nettype wire

// ----- hw/rtl/priority_ready_queue.sv -----
// Top level of the priority ready queue: a sorted chain of cells with request control.
// On accept the request is compared in every cell at once; in the apply state the chain
// shifts and the result register is loaded.
// A result is offered on the out side right after that update edge;
// while an earlier result waits unaccepted the update is held back.
// Reset clears the occupancy count, the control state and the result valid; slot contents
// are left as they are and need no clearing pass.
`default_nettype none

module priority_ready_queue #(
  parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // tdata: pid[15:0], priority_req[19:16], arrival[51:20], ready_time[83:52], zero pad
  input  wire logic [prq_pkg::IN_TDATA_W-1:0]   in_tdata,
  // tuser: op
  input  wire logic                             in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // tdata: selected_pid[15:0]
  output logic      [prq_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // tuser: status[1:0]
  output logic      [1:0]                       out_tuser
);
  import prq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  entry_t req_r;
  logic   op_r;
  logic   bad_r;

  logic       out_valid_r;
  status_t    out_status_r, status_nxt;
  logic [PID_W-1:0] out_pid_r, pid_nxt;

  entry_t              cmp_item;
  logic [TIME_W-1:0]   in_arrival;
  logic                cap;
  logic                apply_go;
  logic                ins_ok;
  logic                sel_ok;
  logic                dup_any;

  entry_t     cell_entry [QUEUE_DEPTH];
  cell_flag_t cell_flag  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] bef;
  logic [QUEUE_DEPTH-1:0] dup;

  assign cmp_item.pid   = in_tdata[15:0];
  assign cmp_item.prio  = in_tdata[19:16];
  assign in_arrival     = in_tdata[51:20];
  assign cmp_item.ready = in_tdata[83:52];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_APPLY;
      ST_APPLY: if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    in_tready = 1'b0;
    apply_go  = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_tready = 1'b1;
      ST_APPLY: apply_go  = !out_valid_r || out_tready;
      default:  in_tready = 1'b0;
    endcase
  end

  assign cap = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      req_r <= cmp_item;
      op_r  <= in_tuser;
      bad_r <= (cmp_item.pid == PID_NONE) || (cmp_item.prio > MAX_PRIO) ||
               (cmp_item.ready < in_arrival);
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctl_t ctl;
    entry_t    left_e;
    entry_t    right_e;
    logic      prev_ahead;

    if (i == 0) begin : g_head
      assign left_e     = req_r;
      assign prev_ahead = 1'b0;
    end else begin : g_body
      assign left_e     = cell_entry[i-1];
      assign prev_ahead = bef[i-1];
    end

    // The tail cell has no right neighbor; after a removal it falls outside the count.
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = cell_entry[i];
    end else begin : g_mid
      assign right_e = cell_entry[i+1];
    end

    assign ctl.cap        = cap;
    assign ctl.load_new   = apply_go && (op_r == OP_INSERT) && ins_ok && bef[i] && !prev_ahead;
    assign ctl.take_left  = apply_go && (op_r == OP_INSERT) && ins_ok && bef[i] && prev_ahead;
    assign ctl.take_right = apply_go && (op_r == OP_SELECT) && sel_ok;

    assign bef[i] = cell_flag[i].ahead;
    assign dup[i] = cell_flag[i].dup;

    prq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .valid       (count_r > CW'(i)),
      .cmp_item    (cmp_item),
      .new_item    (req_r),
      .left_entry  (left_e),
      .right_entry (right_e),
      .entry       (cell_entry[i]),
      .flag        (cell_flag[i])
    );
  end

  assign dup_any = |dup;
  assign ins_ok  = !bad_r && !dup_any && (count_r != CW'(QUEUE_DEPTH));
  assign sel_ok  = (count_r != '0);

  always_comb begin
    count_nxt  = count_r;
    status_nxt = STAT_REJECTED;
    pid_nxt    = PID_NONE;
    if (op_r == OP_INSERT) begin
      if (ins_ok) begin
        status_nxt = STAT_INSERTED;
        count_nxt  = count_r + CW'(1);
      end
    end else if (sel_ok) begin
      status_nxt = STAT_SELECTED;
      pid_nxt    = cell_entry[0].pid;
      count_nxt  = count_r - CW'(1);
    end else begin
      status_nxt = STAT_EMPTY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (apply_go) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      out_status_r <= status_nxt;
      out_pid_r    <= pid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pid_r;
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire
